// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define MLBP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define MLBP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, always checked (used for reset behavior).
`define MLBP_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mlbp_pkg.sv =====
// Package: widths, constants and queue entry type for the basis product block.
`timescale 1ns / 1ps
package mlbp_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int LEVEL_MAX   = 16;

   localparam int X_W         = FRAC_BITS + 1;
   localparam int LVL_W       = 5;
   localparam int IDX_W       = 16;
   localparam int FACTOR_W    = FRAC_BITS + 2;
   localparam int T_W         = FRAC_BITS + LEVEL_MAX + 2;
   localparam int PROD_W      = X_W + FACTOR_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [X_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic                last_dim;
   } queue_entry_type;

endpackage

// ===== hw/rtl/mlbp_front.sv =====
// Front end: takes input items and works out each dimension's basis factor.
`timescale 1ns / 1ps
module mlbp_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mlbp_pkg::X_W-1:0]     req_coordinate,
   input  logic [mlbp_pkg::LVL_W-1:0]   req_grid_level,
   input  logic [mlbp_pkg::IDX_W-1:0]   req_grid_index,
   input  logic                         req_last_dim,
   input  logic                         queue_full,
   output logic                         push,
   output mlbp_pkg::queue_entry_type    push_entry
);
   import mlbp_pkg::*;

   logic [X_W-1:0]      x_sat;
   logic [LVL_W-1:0]    lvl;
   logic [T_W-1:0]      one_t;
   logic [T_W-1:0]      two_t;
   logic [T_W-1:0]      t;
   logic [T_W-1:0]      ip;
   logic [T_W-1:0]      top_idx;
   logic [T_W-1:0]      up;
   logic [T_W-1:0]      d;
   logic [FACTOR_W-1:0] factor;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      x_sat = (req_coordinate > ONE_FX) ? ONE_FX : req_coordinate;

      if (req_grid_level == '0) begin
         lvl = LVL_W'(1);
      end else if (req_grid_level > LVL_W'(LEVEL_MAX)) begin
         lvl = LVL_W'(LEVEL_MAX);
      end else begin
         lvl = req_grid_level;
      end

      one_t   = T_W'(ONE_FX);
      two_t   = one_t << 1;
      t       = T_W'(x_sat) << lvl;
      ip      = T_W'(req_grid_index) << FRAC_BITS;
      top_idx = (T_W'(1) << lvl) - T_W'(1);
      up      = one_t + t;
      d       = (t >= ip) ? (t - ip) : (ip - t);

      // rules are checked in priority order
      if (lvl == LVL_W'(1)) begin
         factor = FACTOR_W'(ONE_FX);
      end else if (req_grid_index == IDX_W'(1)) begin
         factor = (t < two_t) ? FACTOR_W'(two_t - t) : '0;
      end else if (T_W'(req_grid_index) == top_idx) begin
         factor = (up > ip) ? FACTOR_W'(up - ip) : '0;
      end else begin
         factor = (d < one_t) ? FACTOR_W'(one_t - d) : '0;
      end

      push_entry.factor   = factor;
      push_entry.last_dim = req_last_dim;
   end

endmodule

// ===== hw/rtl/mlbp_queue.sv =====
// Short register queue between the factor front end and the product back end.
`timescale 1ns / 1ps
module mlbp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mlbp_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      not_empty,
   output mlbp_pkg::queue_entry_type pop_entry
);
   import mlbp_pkg::*;

   queue_entry_type   entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/mlbp_back.sv =====
// Back end: folds factors into the running product and holds the result item.
`timescale 1ns / 1ps
module mlbp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      not_empty,
   input  mlbp_pkg::queue_entry_type pop_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [mlbp_pkg::X_W-1:0]  rsp_support
);
   import mlbp_pkg::*;

   logic [X_W-1:0]    product_ff;
   logic [X_W-1:0]    product_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [X_W-1:0]    rsp_support_ff;
   logic [X_W-1:0]    rsp_support_in;
   logic [PROD_W-1:0] full_prod;
   logic [PROD_W-1:0] scaled;
   logic [X_W-1:0]    next_prod;
   logic              out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_support = rsp_support_ff;

   // output slot is free if empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = not_empty && (!pop_entry.last_dim || out_free);

   always_comb begin
      full_prod = PROD_W'(product_ff) * PROD_W'(pop_entry.factor);
      scaled    = full_prod >> FRAC_BITS;
      next_prod = (scaled > PROD_W'(ONE_FX)) ? ONE_FX : scaled[X_W-1:0];

      product_in     = product_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_support_in = rsp_support_ff;
      if (pop) begin
         if (pop_entry.last_dim) begin
            product_in     = ONE_FX;
            rsp_valid_in   = 1'b1;
            rsp_support_in = next_prod;
         end else begin
            product_in = next_prod;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         product_ff   <= ONE_FX;
         rsp_valid_ff <= 1'b0;
      end else begin
         product_ff   <= product_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_support_ff <= rsp_support_in;
   end

endmodule

// ===== hw/rtl/modlinear_basis_product.sv =====
// Top level of the modified-linear sparse grid basis product block.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | coordinate, grid_level, grid_index, last_dim
//   rsp     | out       | rsp_valid/rsp_stall  | support
//
// One item per cycle sustained while the queue is not full; the factor is computed as the item is taken
// and the running-product multiply in the back end sets the loop per cycle.
// A result is registered in the output slot when its last-dimension item is popped from the queue.
// Synchronous reset empties the queue, clears the result and sets the product to one.
// A stalled result holds; the two-entry queue absorbs input while it waits.
`timescale 1ns / 1ps
module modlinear_basis_product (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [mlbp_pkg::X_W-1:0]   req_coordinate,
   input  logic [mlbp_pkg::LVL_W-1:0] req_grid_level,
   input  logic [mlbp_pkg::IDX_W-1:0] req_grid_index,
   input  logic                       req_last_dim,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mlbp_pkg::X_W-1:0]   rsp_support
);
   import mlbp_pkg::*;

   logic            queue_full;
   logic            push;
   logic            pop;
   logic            not_empty;
   queue_entry_type push_entry;
   queue_entry_type pop_entry;

   mlbp_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_coordinate (req_coordinate),
      .req_grid_level (req_grid_level),
      .req_grid_index (req_grid_index),
      .req_last_dim   (req_last_dim),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   mlbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry)
   );

   mlbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .not_empty   (not_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_support (rsp_support)
   );

endmodule

// ===== hw/rtl/mlbp_checker.sv =====
// Port-level checks for the basis product block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mlbp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [mlbp_pkg::X_W-1:0] rsp_support
);
   import mlbp_pkg::*;

   `MLBP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_support), "stalled result item changed")

   `MLBP_ASSERT_IMP(a_support_range, clock, reset, rsp_valid, rsp_support <= ONE_FX, "support above one")

   `MLBP_ASSERT_NXT_ALL(a_reset_clear, clock, reset, !rsp_valid && !req_stall, "reset did not clear result or queue")

endmodule

bind modlinear_basis_product mlbp_checker u_mlbp_checker (.*);

// ===== dv/modlinear_basis_product_tb.sv =====
// Testbench for modlinear_basis_product: directed, random and back-pressure items.
`timescale 1ns / 1ps
module modlinear_basis_product_tb;
   import mlbp_pkg::*;

   localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [X_W-1:0]   req_coordinate;
   logic [LVL_W-1:0] req_grid_level;
   logic [IDX_W-1:0] req_grid_index;
   logic             req_last_dim;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [X_W-1:0]   rsp_support;

   logic [X_W-1:0] model_product;
   logic [X_W-1:0] expected_support[$];
   logic [X_W-1:0] oldest_support;
   int             fail_count;
   int             item_count;
   bit             no_idle;
   int             long_hold_cycles;

   modlinear_basis_product i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_coordinate (req_coordinate),
      .req_grid_level (req_grid_level),
      .req_grid_index (req_grid_index),
      .req_last_dim   (req_last_dim),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_support    (rsp_support)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Factor of one dimension, exact, up to two at the boundaries.
   function automatic logic [FACTOR_W-1:0] basis_factor_fx(logic [X_W-1:0] x_in,
                                                          logic [LVL_W-1:0] lvl_in,
                                                          logic [IDX_W-1:0] idx_in);
      logic [63:0] x, lvl, t, ip, d, f;
      x   = (64'(x_in) > ONE64) ? ONE64 : 64'(x_in);
      lvl = 64'(lvl_in);
      if (lvl == 0) lvl = 64'd1;
      if (lvl > LEVEL_MAX) lvl = 64'(LEVEL_MAX);
      t  = x << lvl;
      ip = 64'(idx_in) << FRAC_BITS;
      if (lvl == 1) begin
         f = ONE64;
      end else if (idx_in == 1) begin
         f = (t < 2 * ONE64) ? (2 * ONE64 - t) : 64'd0;
      end else if (64'(idx_in) == ((64'd1 << lvl) - 1)) begin
         f = (ONE64 + t > ip) ? (ONE64 + t - ip) : 64'd0;
      end else begin
         d = (t >= ip) ? (t - ip) : (ip - t);
         f = (d < ONE64) ? (ONE64 - d) : 64'd0;
      end
      return FACTOR_W'(f);
   endfunction

   // Folds one accepted dimension into the model product; queues the support on the last one.
   task automatic fold_dimension(logic [X_W-1:0] x, logic [LVL_W-1:0] lvl,
                                 logic [IDX_W-1:0] idx, logic last);
      logic [63:0] p;
      p = (64'(model_product) * 64'(basis_factor_fx(x, lvl, idx))) >> FRAC_BITS;
      if (p > ONE64) p = ONE64;
      model_product = X_W'(p);
      if (last) begin
         expected_support.push_back(model_product);
         model_product = ONE_FX;
      end
   endtask

   task automatic send_item(logic [X_W-1:0] x, logic [LVL_W-1:0] lvl,
                            logic [IDX_W-1:0] idx, logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_coordinate <= x;
      req_grid_level <= lvl;
      req_grid_index <= idx;
      req_last_dim   <= last;
      do @(posedge clock); while (req_stall);
      fold_dimension(x, lvl, idx, last);
      item_count++;
   endtask

   // Coordinate close to the grid point so the hat is mostly nonzero.
   function automatic logic [X_W-1:0] coord_near(int lvl, logic [IDX_W-1:0] idx);
      longint c;
      if ($urandom_range(0, 3) == 0) return X_W'($urandom_range(0, 65536));
      c = (longint'(idx) <<< FRAC_BITS) + longint'($urandom_range(0, 131072)) - 65536;
      if (c < 0) c = 0;
      c = c >>> lvl;
      if (c > 65536) c = 65536;
      return X_W'(c);
   endfunction

   // One well-formed point: legal level and odd index per dimension.
   task automatic send_point(int dims);
      int                lvl;
      logic [IDX_W-1:0]  idx;
      for (int d = 0; d < dims; d++) begin
         lvl = $urandom_range(1, LEVEL_MAX);
         case ($urandom_range(0, 3))
            0: idx = IDX_W'(1);
            1: idx = IDX_W'((1 << lvl) - 1);
            default: idx = IDX_W'(($urandom_range(0, (1 << (lvl - 1)) - 1) << 1) | 1);
         endcase
         send_item(coord_near(lvl, idx), LVL_W'(lvl), idx, d == dims - 1);
      end
   endtask

   task automatic test_directed_cases();
      send_item(17'd0, 5'd1, 16'd1, 1'b1);            // level one
      send_item(ONE_FX, 5'd0, 16'd0, 1'b1);           // level zero
      send_item(17'd0, 5'd2, 16'd1, 1'b1);            // left boundary, factor two, saturates
      send_item(ONE_FX, 5'd2, 16'd3, 1'b1);           // right boundary, factor two
      send_item(17'h18000, 5'd2, 16'd1, 1'b0);        // coordinate above one
      send_item(17'h08000, 5'd2, 16'd2, 1'b1);
      send_item(17'd0, 5'd16, 16'd1, 1'b1);
      send_item(ONE_FX, 5'd16, 16'hFFFF, 1'b1);
      send_item(17'h1FFFF, 5'd31, 16'hFFFF, 1'b1);    // level above max
      send_item(17'h07FFF, 5'd17, 16'h7FFF, 1'b1);
      send_item(17'd0, 5'd3, 16'd0, 1'b1);            // index zero
      send_item(17'h08000, 5'd2, 16'd2, 1'b1);        // even index
      send_item(17'h04000, 5'd4, 16'hFFFF, 1'b1);     // index too large
      send_item(17'h02AAB, 5'd3, 16'd1, 1'b0);        // truncation across dimensions
      send_item(17'h05555, 5'd3, 16'd3, 1'b0);
      send_item(17'h01234, 5'd4, 16'd5, 1'b1);
      send_item(17'h0C000, 5'd2, 16'd3, 1'b0);        // product carries on
      send_item(17'h06000, 5'd3, 16'd3, 1'b0);
      send_item(17'h0A000, 5'd4, 16'd11, 1'b1);
      send_item(17'h00001, 5'd16, 16'd1, 1'b1);
      send_item(17'h1FFFF, 5'h1F, 16'hFFFF, 1'b1);
      send_item(17'h0FFFF, 5'd15, 16'h5555, 1'b0);
      send_item(17'h10001, 5'd8, 16'hAAAA, 1'b1);
   endtask

   task automatic test_random_points();
      int n;
      while (item_count < 500) begin
         no_idle = (item_count >= 200 && item_count < 280);
         if ($urandom_range(0, 4) != 0) begin
            send_point($urandom_range(1, 6));
         end else begin
            // noise: any field value, broken sequences
            n = $urandom_range(1, 4);
            repeat (n) send_item(X_W'($urandom), LVL_W'($urandom), IDX_W'($urandom),
                                 1'($urandom));
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_output_backpressure();
      long_hold_cycles = 250;
      no_idle = 1'b1;
      repeat (40) send_point(1);
      no_idle = 1'b0;
      repeat (10) send_point($urandom_range(1, 3));
   endtask

   // Result side stall: random hold per result, or one long hold on request.
   initial begin
      int n;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         if (long_hold_cycles > 0) begin
            n = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            n = no_idle ? 0 : $urandom_range(0, 17);
         end
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_support.size() == 0) begin
            $error("support: expected none, actual %0d", rsp_support);
            fail_count++;
         end else begin
            oldest_support = expected_support.pop_front();
            if (rsp_support !== oldest_support) begin
               $error("support: expected %0d, actual %0d", oldest_support, rsp_support);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("modlinear_basis_product regression: fail");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_coordinate   = '0;
      req_grid_level   = '0;
      req_grid_index   = '0;
      req_last_dim     = 1'b0;
      model_product    = ONE_FX;
      fail_count       = 0;
      item_count       = 0;
      no_idle          = 1'b0;
      long_hold_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_points();
      test_output_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_support.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      // leftover partial product from noise causes no result, so nothing else is pending
      if (fail_count == 0) begin
         $display("modlinear_basis_product regression: pass");
      end else begin
         $display("modlinear_basis_product regression: fail");
      end
      $finish;
   end

endmodule
